### rtl/ucs_pkg.sv
// Shared constants, command codes and status struct for the UCB1 child selector.
// No dependencies; imported by every other file of the block.
package ucs_pkg;

   localparam int MAX_CHILDREN_DEF = 64;
   localparam int FRAC_BITS_DEF    = 16;

   localparam int N_W          = 31;
   localparam int W_W          = 32;
   localparam int WEIGHT_W     = 18;
   localparam int LN_W         = 37;
   localparam int SQ_STEPS     = 32;
   localparam int SQRT_STEPS   = 31;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;

   localparam logic [31:0]         LN2_Q32      = 32'd2977044472;
   localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 18'd25907;
   localparam logic                CSR_IDX_WEIGHT = 1'b0;

   typedef enum logic [4:0] {
      CMD_NOP,
      CMD_LOAD,
      CMD_DIVQ_LOAD,
      CMD_DIV_STEP,
      CMD_QSAVE,
      CMD_NORM,
      CMD_SQ_INIT,
      CMD_SQ_STEP,
      CMD_LN_F,
      CMD_LN_E,
      CMD_LN_SUM,
      CMD_DIVR_LOAD,
      CMD_SQRT_LOAD,
      CMD_SQRT_STEP,
      CMD_EXP_MUL,
      CMD_SCORE,
      CMD_FINISH
   } cmd_type;

   typedef struct packed {
      logic full;
      logic n_zero;
      logic tiny_parent;
      logic norm_done;
      logic last;
      logic out_busy;
   } stat_type;

endpackage

### rtl/ucs_if.sv
// Valid/ready channel interfaces for the child beats and the result beats.
// Depends on ucs_pkg for field widths.
interface ucs_req_if import ucs_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [N_W-1:0]   parent_visits;
   logic [N_W-1:0]   child_visits;
   logic [W_W-1:0]   child_wins;
   logic             last_child;

   modport source (output valid, parent_visits, child_visits, child_wins, last_child,
                   input ready);
   modport sink   (input valid, parent_visits, child_visits, child_wins, last_child,
                   output ready);
endinterface

interface ucs_rsp_if #(
   parameter int IDX_W   = 6,
   parameter int SCORE_W = 21
) ();
   logic               valid;
   logic               ready;
   logic [IDX_W-1:0]   best_index;
   logic [SCORE_W-1:0] best_score;

   modport source (output valid, best_index, best_score, input ready);
   modport sink   (input valid, best_index, best_score, output ready);
endinterface

### rtl/ucs_csr.sv
// APB-style register file holding the exploration weight.
// Depends on ucs_pkg.
module ucs_csr import ucs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output logic [WEIGHT_W-1:0]   weight
);

   logic [WEIGHT_W-1:0] weight_ff;
   logic [WEIGHT_W-1:0] weight_in;

   always_comb begin
      weight_in = weight_ff;
      if (psel && penable && pwrite && (paddr[2] == CSR_IDX_WEIGHT)) begin
         weight_in = pwdata[WEIGHT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff <= WEIGHT_RESET;
      end else begin
         weight_ff <= weight_in;
      end
   end

   assign prdata = (paddr[2] == CSR_IDX_WEIGHT) ?
                   {{(CSR_DATA_W-WEIGHT_W){1'b0}}, weight_ff} : '0;
   assign pready = 1'b1;
   assign weight = weight_ff;

endmodule

### rtl/ucs_ctrl.sv
// Sequencer for the scoring of one child: issues datapath commands per cycle.
// Depends on ucs_pkg for command codes and the status struct.
module ucs_ctrl import ucs_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   localparam int DW = 32 + FRAC_BITS;
   localparam int CW = $clog2(DW);
   localparam logic [CW-1:0] DIV_LAST  = CW'(DW - 1);
   localparam logic [CW-1:0] SQ_LAST   = CW'(SQ_STEPS - 1);
   localparam logic [CW-1:0] SQRT_LAST = CW'(SQRT_STEPS - 1);

   typedef enum logic [4:0] {
      S_IDLE, S_CHECK, S_QDIV, S_QSAVE, S_NORM, S_SQ_INIT, S_SQ, S_LN_F, S_LN_E,
      S_LN_SUM, S_RDIV_LOAD, S_RDIV, S_SQRT_LOAD, S_SQRT, S_EXP, S_SCORE, S_FINISH
   } state_type;

   state_type     state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = CMD_NOP;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd      = CMD_LOAD;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (stat.full) begin
               state_in = S_FINISH;
            end else if (stat.n_zero) begin
               state_in = S_SCORE;
            end else begin
               cmd      = CMD_DIVQ_LOAD;
               cnt_in   = '0;
               state_in = S_QDIV;
            end
         end
         S_QDIV: begin
            cmd    = CMD_DIV_STEP;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) begin
               state_in = S_QSAVE;
            end
         end
         S_QSAVE: begin
            cmd      = CMD_QSAVE;
            state_in = stat.tiny_parent ? S_LN_SUM : S_NORM;
         end
         S_NORM: begin
            cmd = CMD_NORM;
            if (stat.norm_done) begin
               state_in = S_SQ_INIT;
            end
         end
         S_SQ_INIT: begin
            cmd      = CMD_SQ_INIT;
            cnt_in   = '0;
            state_in = S_SQ;
         end
         S_SQ: begin
            cmd    = CMD_SQ_STEP;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == SQ_LAST) begin
               state_in = S_LN_F;
            end
         end
         S_LN_F: begin
            cmd      = CMD_LN_F;
            state_in = S_LN_E;
         end
         S_LN_E: begin
            cmd      = CMD_LN_E;
            state_in = S_LN_SUM;
         end
         S_LN_SUM: begin
            cmd      = CMD_LN_SUM;
            state_in = S_RDIV_LOAD;
         end
         S_RDIV_LOAD: begin
            cmd      = CMD_DIVR_LOAD;
            cnt_in   = '0;
            state_in = S_RDIV;
         end
         S_RDIV: begin
            cmd    = CMD_DIV_STEP;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) begin
               state_in = S_SQRT_LOAD;
            end
         end
         S_SQRT_LOAD: begin
            cmd      = CMD_SQRT_LOAD;
            cnt_in   = '0;
            state_in = S_SQRT;
         end
         S_SQRT: begin
            cmd    = CMD_SQRT_STEP;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == SQRT_LAST) begin
               state_in = S_EXP;
            end
         end
         S_EXP: begin
            cmd      = CMD_EXP_MUL;
            state_in = S_SCORE;
         end
         S_SCORE: begin
            cmd      = CMD_SCORE;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!(stat.last && stat.out_busy)) begin
               cmd      = CMD_FINISH;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

### rtl/ucs_dp.sv
// Datapath: shared divider, multiplier, square-root unit, lead tracking, result register.
// Depends on ucs_pkg; driven by commands from ucs_ctrl.
module ucs_dp import ucs_pkg::*; #(
   parameter int MAX_CHILDREN = MAX_CHILDREN_DEF,
   parameter int FRAC_BITS    = FRAC_BITS_DEF,
   parameter int IW           = $clog2(MAX_CHILDREN),
   parameter int SW           = 5 + FRAC_BITS
) (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output stat_type            stat,
   input  logic [WEIGHT_W-1:0] weight,
   input  logic [N_W-1:0]      parent_visits,
   input  logic [N_W-1:0]      child_visits,
   input  logic [W_W-1:0]      child_wins,
   input  logic                last_child,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [IW-1:0]       best_index,
   output logic [SW-1:0]       best_score
);

   localparam int DW    = 32 + FRAC_BITS;
   localparam int SUM_W = DW + 1;
   localparam int CNTW  = $clog2(MAX_CHILDREN + 1);
   localparam int EXP_W = 20 + FRAC_BITS;
   localparam int SHR   = 44 - FRAC_BITS;

   logic [N_W-1:0]   n_ff;
   logic [W_W-1:0]   w_ff;
   logic             last_ff;
   logic             small_ff;
   logic [31:0]      x_ff;
   logic [4:0]       e_ff;
   logic [DW-1:0]    dvd_ff, quo_ff, q_ff;
   logic [31:0]      dvs_ff, rem_ff;
   logic [31:0]      frac_ff;
   logic [63:0]      prod_ff;
   logic [LN_W-1:0]  ln_ff;
   logic [61:0]      v_ff;
   logic [32:0]      srem_ff;
   logic [30:0]      root_ff;
   logic [SW-1:0]    score_ff;
   logic [CNTW-1:0]  count_ff;
   logic [IW-1:0]    lead_idx_ff;
   logic [SW-1:0]    lead_score_ff;
   logic             have_lead_ff;
   logic             rsp_valid_ff;
   logic [IW-1:0]    rsp_idx_ff;
   logic [SW-1:0]    rsp_score_ff;

   logic [32:0]      rem_sh;
   logic             div_ge;
   logic [32:0]      rem_diff;
   logic [32:0]      sq_t;
   logic [31:0]      m_next;
   logic [34:0]      srem_sh, trial, srem_diff;
   logic             sqrt_ge;
   logic [31:0]      mul_a, mul_b;
   logic [SUM_W-1:0] total, q_ext, diff;
   logic [SW-1:0]    score_calc;
   logic             full, upd;
   logic [IW-1:0]    new_idx;
   logic [SW-1:0]    new_score;

   assign full = count_ff >= CNTW'(MAX_CHILDREN);

   assign rem_sh   = {rem_ff, dvd_ff[DW-1]};
   assign div_ge   = rem_sh >= {1'b0, dvs_ff};
   assign rem_diff = rem_sh - {1'b0, dvs_ff};

   assign sq_t   = prod_ff[63:31];
   assign m_next = sq_t[32] ? sq_t[32:1] : sq_t[31:0];

   assign srem_sh   = {srem_ff, v_ff[61:60]};
   assign trial     = {2'b00, root_ff, 2'b01};
   assign sqrt_ge   = srem_sh >= trial;
   assign srem_diff = srem_sh - trial;

   always_comb begin
      mul_a = prod_ff[31:0];
      mul_b = prod_ff[31:0];
      case (cmd)
         CMD_SQ_INIT: begin
            mul_a = x_ff;
            mul_b = x_ff;
         end
         CMD_SQ_STEP: begin
            mul_a = m_next;
            mul_b = m_next;
         end
         CMD_LN_F: begin
            mul_a = frac_ff;
            mul_b = LN2_Q32;
         end
         CMD_LN_E: begin
            mul_a = {27'd0, e_ff};
            mul_b = LN2_Q32;
         end
         CMD_EXP_MUL: begin
            mul_a = {{(32-WEIGHT_W){1'b0}}, weight};
            mul_b = {1'b0, root_ff};
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      total = SUM_W'(prod_ff[63:SHR]) + (SUM_W'(1) << FRAC_BITS);
      q_ext = SUM_W'(q_ff);
      diff  = total - q_ext;
      if (n_ff == '0) begin
         score_calc = '1;
      end else if (q_ext >= total) begin
         score_calc = '0;
      end else if (diff[SUM_W-1:SW] != '0) begin
         score_calc = '1;
      end else begin
         score_calc = diff[SW-1:0];
      end
   end

   assign upd       = !full && (!have_lead_ff || (score_ff > lead_score_ff));
   assign new_idx   = upd ? count_ff[IW-1:0] : lead_idx_ff;
   assign new_score = upd ? score_ff : lead_score_ff;

   always_ff @(posedge clock) begin
      case (cmd)
         CMD_LOAD: begin
            n_ff     <= child_visits;
            w_ff     <= child_wins;
            last_ff  <= last_child;
            small_ff <= parent_visits <= N_W'(1);
            x_ff     <= {1'b0, parent_visits};
            e_ff     <= 5'd31;
         end
         CMD_DIVQ_LOAD: begin
            dvd_ff <= {w_ff, {FRAC_BITS{1'b0}}};
            dvs_ff <= {n_ff, 1'b0};
            rem_ff <= '0;
         end
         CMD_DIVR_LOAD: begin
            dvd_ff <= DW'(ln_ff);
            dvs_ff <= {1'b0, n_ff};
            rem_ff <= '0;
         end
         CMD_DIV_STEP: begin
            dvd_ff <= {dvd_ff[DW-2:0], 1'b0};
            quo_ff <= {quo_ff[DW-2:0], div_ge};
            rem_ff <= div_ge ? rem_diff[31:0] : rem_sh[31:0];
         end
         CMD_QSAVE: begin
            q_ff <= quo_ff;
         end
         CMD_NORM: begin
            if (!x_ff[31]) begin
               x_ff <= {x_ff[30:0], 1'b0};
               e_ff <= e_ff - 1'b1;
            end
         end
         CMD_SQ_INIT: begin
            prod_ff <= mul_a * mul_b;
            frac_ff <= '0;
         end
         CMD_SQ_STEP: begin
            prod_ff <= mul_a * mul_b;
            frac_ff <= {frac_ff[30:0], sq_t[32]};
         end
         CMD_LN_F: begin
            prod_ff <= mul_a * mul_b;
         end
         CMD_LN_E: begin
            prod_ff <= mul_a * mul_b;
            ln_ff   <= LN_W'(prod_ff[63:32]);
         end
         CMD_LN_SUM: begin
            ln_ff <= small_ff ? '0 : ln_ff + prod_ff[LN_W-1:0];
         end
         CMD_SQRT_LOAD: begin
            v_ff    <= {1'b0, quo_ff[LN_W-1:0], 24'd0};
            srem_ff <= '0;
            root_ff <= '0;
         end
         CMD_SQRT_STEP: begin
            v_ff    <= {v_ff[59:0], 2'b00};
            srem_ff <= sqrt_ge ? srem_diff[32:0] : srem_sh[32:0];
            root_ff <= {root_ff[29:0], sqrt_ge};
         end
         CMD_EXP_MUL: begin
            prod_ff <= mul_a * mul_b;
         end
         CMD_SCORE: begin
            score_ff <= score_calc;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         lead_idx_ff   <= '0;
         lead_score_ff <= '0;
         have_lead_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if ((cmd == CMD_FINISH) && last_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd == CMD_FINISH) begin
            if (last_ff) begin
               count_ff      <= '0;
               lead_idx_ff   <= '0;
               lead_score_ff <= '0;
               have_lead_ff  <= 1'b0;
            end else begin
               lead_idx_ff   <= new_idx;
               lead_score_ff <= new_score;
               have_lead_ff  <= have_lead_ff || upd;
               if (!full) begin
                  count_ff <= count_ff + 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if ((cmd == CMD_FINISH) && last_ff) begin
         rsp_idx_ff   <= new_idx;
         rsp_score_ff <= new_score;
      end
   end

   assign stat.full        = full;
   assign stat.n_zero      = (n_ff == '0);
   assign stat.tiny_parent = small_ff;
   assign stat.norm_done   = x_ff[31];
   assign stat.last        = last_ff;
   assign stat.out_busy    = rsp_valid_ff && !rsp_ready;

   assign rsp_valid  = rsp_valid_ff;
   assign best_index = rsp_idx_ff;
   assign best_score = rsp_score_ff;

   a_list_close: assert property (@(posedge clock) disable iff (reset)
      (cmd == CMD_FINISH) && last_ff |=> rsp_valid_ff && (count_ff == '0) && !have_lead_ff)
      else $error("list close did not post a result and clear the lead");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (cmd == CMD_FINISH) && !last_ff && !full |=>
      count_ff == CNTW'($past(count_ff) + 1'b1))
      else $error("child count did not advance");

   a_overflow_hold: assert property (@(posedge clock) disable iff (reset)
      (cmd == CMD_FINISH) && !last_ff && full |=> $stable(lead_score_ff) && $stable(count_ff))
      else $error("lead changed on a child past the list limit");

endmodule

### rtl/uct_child_select.sv
// Top level of the UCB1 child selector: register port, sequencer and datapath.
// Depends on ucs_pkg, ucs_if, ucs_csr, ucs_ctrl and ucs_dp.
//
// Usage: send a node's children as beats on req, one child per beat, with
// last_child set on the final one. Each child is scored by UCB1 in unsigned
// Q5.FRAC_BITS; on the last beat one rsp beat carries the index and score of
// the first child with the strictly highest score. Unvisited children score
// all ones. Children beyond MAX_CHILDREN are ignored but still close a list.
// One child is in work at a time. A visited child passes in order through
// the first pass of the bit-serial divider, the normalize shift of the parent
// count (1 to 30 places), the 32 squarings of the logarithm, the second
// divider pass, the square root and the score; when the parent count is 0 or
// 1 the shift and the squarings are skipped. An unvisited child goes straight
// to the score, an overflowing one straight to the finish. The result appears
// in the cycle after the last child finishes and waits in an output register;
// while the receiver stalls, further children are taken and scored, and only
// the next last child holds until the previous result beat is taken. Reset
// clears the running list and the result valid flag and loads the exploration
// weight with its default; the weight is written over the APB port at any
// address with paddr[2] clear (0 to 3).
module uct_child_select import ucs_pkg::*; #(
   parameter int MAX_CHILDREN = MAX_CHILDREN_DEF,
   parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   ucs_req_if.sink               req,
   ucs_rsp_if.source             rsp,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int IW = $clog2(MAX_CHILDREN);
   localparam int SW = 5 + FRAC_BITS;

   logic [WEIGHT_W-1:0] weight;
   cmd_type             cmd;
   stat_type            stat;
   logic                ready;

   ucs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .weight  (weight)
   );

   ucs_ctrl #(.FRAC_BITS(FRAC_BITS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ucs_dp #(
      .MAX_CHILDREN (MAX_CHILDREN),
      .FRAC_BITS    (FRAC_BITS),
      .IW           (IW),
      .SW           (SW)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .weight        (weight),
      .parent_visits (req.parent_visits),
      .child_visits  (req.child_visits),
      .child_wins    (req.child_wins),
      .last_child    (req.last_child),
      .rsp_valid     (rsp.valid),
      .rsp_ready     (rsp.ready),
      .best_index    (rsp.best_index),
      .best_score    (rsp.best_score)
   );

   assign req.ready = ready;

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> !req.ready)
      else $error("new child beat taken while one is in work");

endmodule
